>>> hdl/jdtg_pkg.sv
package jdtg_pkg;

  localparam int TimerBits = 16;
  localparam int QueueDepth = 2;
  localparam int CordW = 34;
  localparam int MvW = 13;
  localparam logic [23:0] RecipM = 24'd8396809;

  typedef enum logic [2:0] {
    REG_DEAD_RADIUS  = 3'd0,
    REG_LOWER_FREQ   = 3'd1,
    REG_UPPER_FREQ   = 3'd2,
    REG_TRACKER_FREQ = 3'd3,
    REG_CLOCK_HZ     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [9:0]  x_code;
    logic [9:0]  y_code;
    logic [9:0]  button_code;
  } item_t;

  typedef struct packed {
    logic [11:0] dead_radius;
    logic [15:0] lower_freq;
    logic [15:0] upper_freq;
    logic [15:0] tracker_freq;
    logic [24:0] clock_hz;
  } cfg_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/joystick_direction_tone_generator_unit.sv
// joystick direction tone generator
// input queue: drive the item fields and push; an item is taken on a clock
// edge with push high and full low. two items can wait in the input queue.
// results: while empty is low the oldest result is on the result ports; pop
// takes it. every item gives exactly one result, in order.
// config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high. write only while the block is idle.
// timing: a tick item is handled in the execution unit's idle state, so ticks
// flow at one per cycle while pop keeps up. a joystick sample passes through
// scaling and the dead-zone test, the angle iterations, the frequency
// scaling, the frequency pick, the bit-serial half-period divider (skipped
// when the tone is off) and the result load; a sample inside the dead zone
// skips the angle iterations and the frequency scaling.
// a tick's result is registered once the tick leaves the input queue.
// reset: config returns to its defaults, the timer, compare point and reload
// clear, tone and tracker are off, the pin state is high; the queues empty.
// when pop stays low the result is held, the execution unit waits and the
// input queue fills until full rises.
module joystick_direction_tone_generator_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [9:0]  x_code_i,
  input  logic [9:0]  y_code_i,
  input  logic [9:0]  button_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] freq_out_o,
  output logic [15:0] half_period_o,
  output logic        tracker_on_o,
  output logic        tone_on_o,
  output logic        pin_a_o,
  output logic        pin_b_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  jdtg_pkg::cfg_t  cfg_q;
  jdtg_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign cfg_ready_o = 1'b1;
  assign in_item = '{action: action_i, x_code: x_code_i, y_code: y_code_i,
                     button_code: button_code_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_radius  <= 12'd500;
      cfg_q.lower_freq   <= 16'd16000;
      cfg_q.upper_freq   <= 16'd16500;
      cfg_q.tracker_freq <= 16'd15000;
      cfg_q.clock_hz     <= 25'd16000000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jdtg_pkg::REG_DEAD_RADIUS:  cfg_q.dead_radius  <= cfg_data_i[11:0];
        jdtg_pkg::REG_LOWER_FREQ:   cfg_q.lower_freq   <= cfg_data_i[15:0];
        jdtg_pkg::REG_UPPER_FREQ:   cfg_q.upper_freq   <= cfg_data_i[15:0];
        jdtg_pkg::REG_TRACKER_FREQ: cfg_q.tracker_freq <= cfg_data_i[15:0];
        jdtg_pkg::REG_CLOCK_HZ:     cfg_q.clock_hz     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  jdtg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_take_i  (q_take)
  );

  jdtg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_take_o   (q_take),
    .empty         (empty),
    .pop           (pop),
    .freq_out_o    (freq_out_o),
    .half_period_o (half_period_o),
    .tracker_on_o  (tracker_on_o),
    .tone_on_o     (tone_on_o),
    .pin_a_o       (pin_a_o),
    .pin_b_o       (pin_b_o)
  );

endmodule

>>> hdl/jdtg_front.sv
module jdtg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  jdtg_pkg::item_t item_i,
  output logic            item_valid_o,
  output jdtg_pkg::item_t item_o,
  input  logic            item_take_i
);

  jdtg_pkg::item_t mem_q [jdtg_pkg::QueueDepth];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic wr_en, rd_en;

  assign full         = (count_q == 2'(jdtg_pkg::QueueDepth));
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) count_d = count_q + 2'd1;
    else if (!wr_en && rd_en) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= item_i;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(jdtg_pkg::QueueDepth)) else $error("queue overflow");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + 2'd1)) else $error("count");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q)) else $error("ptr");

endmodule

>>> hdl/jdtg_back.sv
module jdtg_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jdtg_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  jdtg_pkg::item_t item_i,
  output logic            item_take_o,
  output logic            empty,
  input  logic            pop,
  output logic [15:0]     freq_out_o,
  output logic [15:0]     half_period_o,
  output logic            tracker_on_o,
  output logic            tone_on_o,
  output logic            pin_a_o,
  output logic            pin_b_o
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CW = jdtg_pkg::CordW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MV1   = 10'b0000000010,
    S_MV2   = 10'b0000000100,
    S_PRE   = 10'b0000001000,
    S_CORD  = 10'b0000010000,
    S_SCALE = 10'b0000100000,
    S_QSEL  = 10'b0001000000,
    S_SEL   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q;
  logic [15:0] timer_q, cmp_q, reload_q;
  logic tone_q, pin_q, trk_q, was_q;
  logic out_valid_q;
  logic [15:0] out_freq_q, out_half_q;
  logic out_trk_q, out_tone_q, out_pin_q;

  logic [22:0] vx_q, vy_q;
  logic pressed_q;
  logic signed [jdtg_pkg::MvW-1:0] mx_q, my_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [IW-1:0] iter_q;
  logic signed [CW+17-1:0] prod_q;
  logic [15:0] freq_q;
  logic [24:0] dvd_q, quo_q;
  logic [17:0] rem_q;
  logic [16:0] dvs_q;
  logic [4:0]  dcnt_q;

  logic out_free, tick_go;
  logic [15:0] timer_inc;
  logic [46:0] px, py;
  logic signed [25:0] r2, lim;
  logic signed [CW-1:0] xe, ye, dx, dy, at;
  logic [16:0] span;
  logic signed [CW+17-1:0] trunc_q;
  logic signed [18:0] qv;
  logic [15:0] fsel;
  logic [17:0] rem_sh;
  logic [25:0] quo_inc;

  assign out_free    = !out_valid_q || pop;
  assign tick_go     = (state_q == S_IDLE) && item_valid_i &&
                       (item_i.action == jdtg_pkg::ACT_TICK) && out_free;
  assign item_take_o = (state_q == S_IDLE) && item_valid_i &&
                       ((item_i.action == jdtg_pkg::ACT_SAMPLE) || out_free);
  assign timer_inc   = timer_q + 16'd1;

  assign px = {24'd0, vx_q} * {23'd0, jdtg_pkg::RecipM};
  assign py = {24'd0, vy_q} * {23'd0, jdtg_pkg::RecipM};
  assign r2 = 26'(mx_q) * 26'(mx_q) + 26'(my_q) * 26'(my_q);
  assign lim = 26'({1'b0, cfg_i.dead_radius} + 13'd1) *
               26'({1'b0, cfg_i.dead_radius} + 13'd1);
  assign xe = CW'(mx_q) <<< 16;
  assign ye = CW'(my_q) <<< 16;
  assign dx = cy_q >>> iter_q;
  assign dy = cx_q >>> iter_q;
  assign at = CW'({2'b00, jdtg_pkg::atan_turns(5'(iter_q))});
  assign span = (cfg_i.upper_freq > cfg_i.lower_freq) ?
                ({1'b0, cfg_i.upper_freq} - {1'b0, cfg_i.lower_freq}) : 17'd0;
  assign trunc_q = (prod_q < 0) ? ((prod_q + (CW+17)'(33'h0FFFFFFFF)) >>> 32)
                                : (prod_q >>> 32);
  assign fsel = trk_q ? cfg_i.tracker_freq : freq_q;
  assign rem_sh = {rem_q[16:0], dvd_q[24]};
  assign quo_inc = {1'b0, quo_q} + 26'd1;

  always_comb begin
    qv = 19'(trunc_q);
    if (qv < 0) qv = qv + 19'(span);
    if (qv < 0) qv = 19'd0;
    if (qv >= 19'(span)) qv = 19'(span) - 19'd1;
    if (span == 17'd0) qv = 19'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      timer_q     <= '0;
      cmp_q       <= '0;
      reload_q    <= '0;
      tone_q      <= 1'b0;
      pin_q       <= 1'b1;
      trk_q       <= 1'b0;
      was_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (tick_go) begin
            timer_q <= timer_inc;
            out_valid_q <= 1'b1;
            if (tone_q && timer_inc == cmp_q) begin
              cmp_q <= cmp_q + reload_q;
              pin_q <= !pin_q;
            end
          end else if (item_take_o) begin
            state_q <= S_MV1;
          end
        end
        S_MV1: state_q <= S_MV2;
        S_MV2: state_q <= S_PRE;
        S_PRE: begin
          was_q <= pressed_q;
          if (r2 < lim) begin
            if (pressed_q && !was_q) trk_q <= !trk_q;
            state_q <= S_SEL;
          end else begin
            state_q <= S_CORD;
          end
        end
        S_CORD:  if (iter_q == IW'(CORDIC_STEPS - 1)) state_q <= S_SCALE;
        S_SCALE: state_q <= S_QSEL;
        S_QSEL:  state_q <= S_SEL;
        S_SEL: begin
          tone_q  <= (fsel != 16'd0);
          state_q <= (fsel != 16'd0) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (dcnt_q == 5'd0) begin
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_DIV && dcnt_q == 5'd0) begin
        reload_q <= (quo_inc > 26'd65535) ? 16'hFFFF : quo_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        vx_q      <= 23'(item_i.x_code) * 23'd5000;
        vy_q      <= 23'(item_i.y_code) * 23'd5000;
        pressed_q <= (item_i.button_code == 10'd0);
        if (tick_go) begin
          out_freq_q <= 16'd0;
          out_half_q <= reload_q;
          out_trk_q  <= trk_q;
          out_tone_q <= tone_q;
          out_pin_q  <= (tone_q && timer_inc == cmp_q) ? !pin_q : pin_q;
        end
      end
      S_MV1: begin
        mx_q <= jdtg_pkg::MvW'($signed({1'b0, px[45:33]}) - 14'sd2500);
        my_q <= jdtg_pkg::MvW'($signed({1'b0, py[45:33]}) - 14'sd2500);
      end
      S_MV2: ;
      S_PRE: begin
        freq_q <= 16'd0;
        iter_q <= '0;
        if (xe < 0) begin
          if (ye >= 0) begin
            cx_q <= ye; cy_q <= -xe; cz_q <= CW'(32'sh40000000);
          end else begin
            cx_q <= -ye; cy_q <= xe; cz_q <= -CW'(32'sh40000000);
          end
        end else begin
          cx_q <= xe; cy_q <= ye; cz_q <= '0;
        end
      end
      S_CORD: begin
        iter_q <= iter_q + IW'(1);
        if (cy_q > 0) begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
        end
      end
      S_SCALE: prod_q <= cz_q * $signed({1'b0, span});
      S_QSEL:  freq_q <= cfg_i.lower_freq + 16'(qv);
      S_SEL: begin
        freq_q <= fsel;
        dvd_q  <= cfg_i.clock_hz;
        dvs_q  <= {fsel, 1'b0};
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 5'd25;
      end
      S_DIV: begin
        if (dcnt_q != 5'd0) begin
          dcnt_q <= dcnt_q - 5'd1;
          dvd_q  <= {dvd_q[23:0], 1'b0};
          if (rem_sh >= {1'b0, dvs_q}) begin
            rem_q <= rem_sh - {1'b0, dvs_q};
            quo_q <= {quo_q[23:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[23:0], 1'b0};
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_freq_q <= freq_q;
          out_half_q <= reload_q;
          out_trk_q  <= trk_q;
          out_tone_q <= tone_q;
          out_pin_q  <= pin_q;
        end
      end
      default: ;
    endcase
  end

  assign empty         = !out_valid_q;
  assign freq_out_o    = out_freq_q;
  assign half_period_o = out_half_q;
  assign tracker_on_o  = out_trk_q;
  assign tone_on_o     = out_tone_q;
  assign pin_a_o       = out_pin_q;
  assign pin_b_o       = !out_pin_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(out_freq_q) && $stable(out_pin_q)))
    else $error("result overwritten");
  a_tick_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tone_q && state_q == S_IDLE) |=> $stable(pin_q) || $past(state_q) != S_IDLE)
    else $error("pin moved with tone off");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |-> (state_q == S_IDLE && item_valid_i)) else $error("take");

endmodule
